[hdl/ppt_pkg.sv]
// Shared types and constants for the pointer position tracker.
// No dependencies; imported by the tracker and its checker.
package ppt_pkg;

  localparam int COORD_LIMIT = 4096;
  localparam int COORD_W     = 12;
  localparam int DELTA_W     = 13;
  localparam int BOUND_W     = 13;
  localparam int ABS_W       = 16;
  localparam int PKT_W       = 8;
  localparam int BTN_W       = 3;
  localparam int CFG_INDEX_W = 8;
  // wide enough for a 16-bit absolute value or a 12-bit position plus a byte delta
  localparam int TGT_W       = 17;

  localparam logic [BOUND_W-1:0] DEFAULT_WIDTH  = BOUND_W'(1024);
  localparam logic [BOUND_W-1:0] DEFAULT_HEIGHT = BOUND_W'(768);
  localparam logic [BOUND_W-1:0] BOUND_MAX      = BOUND_W'(COORD_LIMIT);
  localparam logic [COORD_W-1:0] RESET_X        = COORD_W'(400);
  localparam logic [COORD_W-1:0] RESET_Y        = COORD_W'(300);

  localparam int BTN_LEFT   = 0;
  localparam int BTN_RIGHT  = 1;
  localparam int BTN_MIDDLE = 2;

  typedef enum logic {
    OP_ABS = 1'b0,
    OP_REL = 1'b1
  } op_t;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_BOUND  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_BOUND = CFG_INDEX_W'(1);

  typedef struct packed {
    op_t              op;
    logic [ABS_W-1:0] abs_x;
    logic [ABS_W-1:0] abs_y;
    logic [BTN_W-1:0] abs_buttons;
    logic [PKT_W-1:0] pkt_status;
    logic [PKT_W-1:0] pkt_dx;
    logic [PKT_W-1:0] pkt_dy;
  } item_t;

  // Zero picks the default, anything past the coordinate range saturates.
  function automatic logic [BOUND_W-1:0] eff_bound(logic [BOUND_W-1:0] raw,
                                                   logic [BOUND_W-1:0] dflt);
    logic [BOUND_W-1:0] b;
    b = (raw == '0) ? dflt : raw;
    if (b > BOUND_MAX) b = BOUND_MAX;
    return b;
  endfunction

  // Clamp to 0 .. bound-1; bound is never zero.
  function automatic logic [COORD_W-1:0] clamp_coord(logic signed [TGT_W-1:0] v,
                                                     logic [BOUND_W-1:0] bound);
    logic signed [TGT_W-1:0] b;
    logic [BOUND_W-1:0]      top;
    b   = $signed(TGT_W'(bound));
    top = bound - BOUND_W'(1);
    if (v < 0) return '0;
    else if (v >= b) return top[COORD_W-1:0];
    else return v[COORD_W-1:0];
  endfunction

endpackage

[hdl/pointer_position_tracker.sv]
// Pointer position tracker: absolute reports and relative packets in, clamped
// position, deltas and button edge flags out. Depends on ppt_pkg.
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------------
//  item    | item_valid / item_stall   | op, abs_x, abs_y, abs_buttons, pkt_status,
//          |                           | pkt_dx, pkt_dy
//  result  | result_valid/result_stall | pos_x, pos_y, delta_x, delta_y, buttons,
//          |                           | moved, left_press, right_press,
//          |                           | left_release, drag
//  cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One item per cycle sustained while result_stall is low; each item passes from its
// item beat into the input register, then through the update logic (add, clamp
// compare, subtract) into the result register.
// Position and button state update when an item moves into the result register.
// rst (synchronous) restores x=400, y=300, no buttons, bounds 1024 x 768.
// A stalled result holds; the input register keeps accepting until it is full.
// cfg_ready is always high; the user writes configuration while the block is idle (not enforced).
module pointer_position_tracker
  import ppt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          op,
  input  logic signed [ABS_W-1:0]       abs_x,
  input  logic signed [ABS_W-1:0]       abs_y,
  input  logic        [BTN_W-1:0]       abs_buttons,
  input  logic        [PKT_W-1:0]       pkt_status,
  input  logic signed [PKT_W-1:0]       pkt_dx,
  input  logic signed [PKT_W-1:0]       pkt_dy,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic        [COORD_W-1:0]     pos_x,
  output logic        [COORD_W-1:0]     pos_y,
  output logic signed [DELTA_W-1:0]     delta_x,
  output logic signed [DELTA_W-1:0]     delta_y,
  output logic        [BTN_W-1:0]       buttons,
  output logic                          moved,
  output logic                          left_press,
  output logic                          right_press,
  output logic                          left_release,
  output logic                          drag,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic        [CFG_INDEX_W-1:0] cfg_index,
  input  logic        [BOUND_W-1:0]     cfg_data
);

  // effective bounds, resolved at write time (default and saturation applied)
  logic [BOUND_W-1:0] width_lim;
  logic [BOUND_W-1:0] height_lim;

  // tracker state
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic [BTN_W-1:0]   cur_buttons;

  // input register
  item_t held;
  logic  held_valid;

  logic advance;
  logic item_beat;

  logic signed [TGT_W-1:0]   tgt_x;
  logic signed [TGT_W-1:0]   tgt_y;
  logic        [COORD_W-1:0] new_x;
  logic        [COORD_W-1:0] new_y;
  logic signed [DELTA_W-1:0] dx;
  logic signed [DELTA_W-1:0] dy;
  logic        [BTN_W-1:0]   new_buttons;
  logic                      any_move;

  assign cfg_ready = 1'b1;

  // the held item moves on whenever the result register is empty or draining
  assign advance    = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !advance;
  assign item_beat  = item_valid && !item_stall;

  always_comb begin
    if (held.op == OP_REL) begin
      tgt_x       = $signed(TGT_W'(cur_x)) + TGT_W'($signed(held.pkt_dx));
      tgt_y       = $signed(TGT_W'(cur_y)) - TGT_W'($signed(held.pkt_dy));
      new_buttons = held.pkt_status[BTN_W-1:0];
    end else begin
      tgt_x       = TGT_W'($signed(held.abs_x));
      tgt_y       = TGT_W'($signed(held.abs_y));
      new_buttons = held.abs_buttons;
    end
    new_x    = clamp_coord(tgt_x, width_lim);
    new_y    = clamp_coord(tgt_y, height_lim);
    dx       = $signed({1'b0, new_x}) - $signed({1'b0, cur_x});
    dy       = $signed({1'b0, new_y}) - $signed({1'b0, cur_y});
    any_move = (dx != '0) || (dy != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_lim  <= DEFAULT_WIDTH;
      height_lim <= DEFAULT_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_WIDTH_BOUND) begin
        width_lim <= eff_bound(cfg_data, DEFAULT_WIDTH);
      end else if (cfg_index == REG_HEIGHT_BOUND) begin
        height_lim <= eff_bound(cfg_data, DEFAULT_HEIGHT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_beat) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_beat) begin
      held.op          <= op_t'(op);
      held.abs_x       <= abs_x;
      held.abs_y       <= abs_y;
      held.abs_buttons <= abs_buttons;
      held.pkt_status  <= pkt_status;
      held.pkt_dx      <= pkt_dx;
      held.pkt_dy      <= pkt_dy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x        <= RESET_X;
      cur_y        <= RESET_Y;
      cur_buttons  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        cur_x        <= new_x;
        cur_y        <= new_y;
        cur_buttons  <= new_buttons;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with the state update
  always_ff @(posedge clk) begin
    if (advance) begin
      pos_x        <= new_x;
      pos_y        <= new_y;
      delta_x      <= dx;
      delta_y      <= dy;
      buttons      <= new_buttons;
      moved        <= any_move;
      left_press   <= !cur_buttons[BTN_LEFT] && new_buttons[BTN_LEFT];
      right_press  <= !cur_buttons[BTN_RIGHT] && new_buttons[BTN_RIGHT];
      left_release <= cur_buttons[BTN_LEFT] && !new_buttons[BTN_LEFT];
      drag         <= new_buttons[BTN_LEFT] && any_move;
    end
  end

endmodule

[hdl/ppt_checker.sv]
// Port-level checks for the pointer position tracker, bound to the top level.
// Depends on ppt_pkg.
module ppt_checker
  import ppt_pkg::*;
(
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_stall,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic        [COORD_W-1:0]     pos_x,
  input logic        [COORD_W-1:0]     pos_y,
  input logic signed [DELTA_W-1:0]     delta_x,
  input logic signed [DELTA_W-1:0]     delta_y,
  input logic        [BTN_W-1:0]       buttons,
  input logic                          moved,
  input logic                          left_press,
  input logic                          left_release,
  input logic                          drag
);

  // a stalled result beat holds its position
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(pos_x) && $stable(pos_y))
    else $error("stalled result changed");

  // reset empties the pipeline: no result the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // moved flag agrees with the deltas
  a_moved: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (moved == ((delta_x != '0) || (delta_y != '0))))
    else $error("moved flag disagrees with deltas");

  // edge and drag flags agree with the reported left button
  a_left_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!drag || (buttons[BTN_LEFT] && moved)) &&
                     (!left_press || buttons[BTN_LEFT]) &&
                     (!left_release || !buttons[BTN_LEFT]))
    else $error("left button flags inconsistent");

endmodule

bind pointer_position_tracker ppt_checker u_ppt_checker (.*);
